// ===== sv/ihrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ihrc_pkg
// Types, codes and helper functions shared by the hex record checker.
// ----------------------------------------------------------------------------
package ihrc_pkg;

   localparam int unsigned MAX_DATA_BYTES_DEF = 16;
   localparam int unsigned POS_W              = 10;
   localparam int unsigned END_LEN            = 11;
   localparam int unsigned HDR_BYTES          = 5;

   localparam logic [POS_W-1:0] POS_MAX = '1;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_EOF  = 1'b1;

   typedef enum logic [1:0] {
      KIND_WORD = 2'd0,
      KIND_LINE = 2'd1,
      KIND_FILE = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      LS_DATA      = 3'd0,
      LS_OTHER     = 3'd1,
      LS_END       = 3'd2,
      LS_NO_COLON  = 3'd3,
      LS_LENGTH    = 3'd4,
      LS_CHECKSUM  = 3'd5,
      LS_MALFORMED = 3'd6,
      LS_TOO_LONG  = 3'd7
   } line_status_type;

   // no fault recorded shares the data code
   localparam line_status_type FAULT_NONE = LS_DATA;

   typedef enum logic [1:0] {
      FS_VALID    = 2'd0,
      FS_BAD_LINE = 2'd1,
      FS_NO_END   = 2'd2
   } file_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_WORD,
      ST_LINE,
      ST_FILE
   } state_type;

   typedef struct packed {
      logic take_char;
      logic clear_line;
      logic clear_file;
      logic word_clear;
      logic emit_word;
      logic emit_line;
      logic emit_file;
      logic last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic            line_empty;
      logic            file_failed;
      line_status_type line_status;
      logic            has_words;
      logic            last_word;
      logic            out_free;
   } dp_status_type;

   // character of the end record text at a position below END_LEN
   function automatic logic [7:0] end_char(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = CHAR_COLON;
         4'd8:    c = 8'h31;
         4'd9:    c = 8'h46;
         4'd10:   c = 8'h46;
         default: c = 8'h30;
      endcase
      return c;
   endfunction

   // {valid, value} of a hex digit in either case
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else begin
         r = 5'd0;
      end
      return r;
   endfunction

endpackage

// ===== sv/ihrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ihrc_ctrl
// Sequencer: takes items, walks line end through word writes, line status
// and file status.
// ----------------------------------------------------------------------------
module ihrc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_command,
   input  logic [7:0]             req_char_in,
   input  ihrc_pkg::dp_status_type dp_status,
   output ihrc_pkg::ctrl_cmd_type  cmd
);
   import ihrc_pkg::*;

   state_type state_ff, state_in;
   logic      eof_ff, eof_in;
   logic      accept;
   logic      is_term;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_term   = (req_command == CMD_EOF) ||
                      (req_char_in == CHAR_CR) || (req_char_in == CHAR_LF);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         eof_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         eof_ff   <= eof_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      eof_in   = eof_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!is_term) begin
                  cmd.take_char = 1'b1;
               end else begin
                  eof_in = (req_command == CMD_EOF);
                  if (dp_status.line_empty || dp_status.file_failed) begin
                     cmd.clear_line = 1'b1;
                     state_in = (req_command == CMD_EOF) ? ST_FILE : ST_IDLE;
                  end else if (dp_status.line_status == LS_DATA &&
                               dp_status.has_words) begin
                     cmd.word_clear = 1'b1;
                     state_in = ST_READ;
                  end else begin
                     state_in = ST_LINE;
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_WORD;
         end
         ST_WORD: begin
            if (dp_status.out_free) begin
               cmd.emit_word = 1'b1;
               state_in = dp_status.last_word ? ST_LINE : ST_READ;
            end
         end
         ST_LINE: begin
            if (dp_status.out_free) begin
               cmd.emit_line  = 1'b1;
               cmd.last       = !eof_ff;
               cmd.clear_line = 1'b1;
               state_in = eof_ff ? ST_FILE : ST_IDLE;
            end
         end
         ST_FILE: begin
            if (dp_status.out_free) begin
               cmd.emit_file  = 1'b1;
               cmd.last       = 1'b1;
               cmd.clear_line = 1'b1;
               cmd.clear_file = 1'b1;
               eof_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/ihrc_dpath.sv =====
// ----------------------------------------------------------------------------
// ihrc_dpath
// Line registers, data byte buffer, status evaluation and result register.
// ----------------------------------------------------------------------------
module ihrc_dpath #(
   parameter int unsigned MAX_DATA_BYTES = ihrc_pkg::MAX_DATA_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              req_char_in,
   input  ihrc_pkg::ctrl_cmd_type  cmd,
   output ihrc_pkg::dp_status_type dp_status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_kind,
   output logic [14:0]             rsp_word_address,
   output logic [15:0]             rsp_word_data,
   output logic [2:0]              rsp_status,
   output logic                    rsp_last
);
   import ihrc_pkg::*;

   localparam int unsigned WORDS  = (MAX_DATA_BYTES + 1) / 2;
   localparam int unsigned WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned BIDX_W = $clog2(MAX_DATA_BYTES + HDR_BYTES + 1);
   localparam logic [BIDX_W-1:0] BIDX_LIMIT = BIDX_W'(MAX_DATA_BYTES + HDR_BYTES);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [3:0]        nib_ff, nib_in;
   logic [BIDX_W-1:0] bidx_ff, bidx_in;
   logic [7:0]        cnt_ff, cnt_in;
   logic [15:0]       off_ff, off_in;
   logic [7:0]        rtype_ff, rtype_in;
   logic [7:0]        sum_ff, sum_in;
   line_status_type   fault_ff, fault_in;
   logic              endm_ff, endm_in;
   logic              failed_ff, failed_in;
   logic              seen_ff, seen_in;
   logic [WIDX_W-1:0] widx_ff, widx_in;

   logic [7:0] even_mem [WORDS];
   logic [7:0] odd_mem  [WORDS];
   logic [7:0] even_rd_ff;
   logic [7:0] odd_rd_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          rsp_kind_ff, rsp_kind_in;
   logic [14:0]       rsp_addr_ff, rsp_addr_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [4:0]        hex;
   logic [7:0]        byte_val;
   logic [BIDX_W-1:0] didx;
   logic              wr_en;
   logic [WIDX_W-1:0] wr_addr;
   line_status_type   line_status;
   file_status_type   file_status;
   logic [6:0]        nwords;

   assign hex      = hex_decode(req_char_in);
   assign byte_val = {nib_ff, hex[3:0]};
   assign didx     = bidx_ff - BIDX_W'(4);
   assign wr_addr  = WIDX_W'(didx >> 1);
   assign nwords   = cnt_ff[7:1];

   // line verdict from the current line registers
   always_comb begin
      if (endm_ff && pos_ff == POS_W'(END_LEN)) begin
         line_status = LS_END;
      end else if (fault_ff != FAULT_NONE) begin
         line_status = fault_ff;
      end else if (!pos_ff[0]) begin
         line_status = LS_MALFORMED;
      end else if (bidx_ff < BIDX_W'(HDR_BYTES) ||
                   9'(bidx_ff) != 9'(cnt_ff) + 9'(HDR_BYTES)) begin
         line_status = LS_LENGTH;
      end else if (sum_ff != 8'd0) begin
         line_status = LS_CHECKSUM;
      end else if (rtype_ff != 8'd0) begin
         line_status = LS_OTHER;
      end else begin
         line_status = LS_DATA;
      end
   end

   always_comb begin
      if (failed_ff) begin
         file_status = FS_BAD_LINE;
      end else if (seen_ff) begin
         file_status = FS_VALID;
      end else begin
         file_status = FS_NO_END;
      end
   end

   assign dp_status.line_empty  = (pos_ff == '0);
   assign dp_status.file_failed = failed_ff;
   assign dp_status.line_status = line_status;
   assign dp_status.has_words   = (nwords != 7'd0);
   assign dp_status.last_word   = (7'(widx_ff) == nwords - 7'd1);
   assign dp_status.out_free    = !rsp_valid_ff || !rsp_stall;

   // line and file registers
   always_comb begin
      pos_in    = pos_ff;
      nib_in    = nib_ff;
      bidx_in   = bidx_ff;
      cnt_in    = cnt_ff;
      off_in    = off_ff;
      rtype_in  = rtype_ff;
      sum_in    = sum_ff;
      fault_in  = fault_ff;
      endm_in   = endm_ff;
      failed_in = failed_ff;
      seen_in   = seen_ff;
      widx_in   = widx_ff;
      wr_en     = 1'b0;

      if (cmd.take_char) begin
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + POS_W'(1);
         end
         if (pos_ff >= POS_W'(END_LEN) || req_char_in != end_char(pos_ff[3:0])) begin
            endm_in = 1'b0;
         end
         if (fault_ff == FAULT_NONE) begin
            if (pos_ff == '0) begin
               if (req_char_in != CHAR_COLON) begin
                  fault_in = LS_NO_COLON;
               end
            end else if (!hex[4]) begin
               fault_in = LS_MALFORMED;
            end else if (bidx_ff >= BIDX_LIMIT) begin
               fault_in = LS_TOO_LONG;
            end else if (pos_ff[0]) begin
               nib_in = hex[3:0];
            end else begin
               case (bidx_ff)
                  BIDX_W'(0): cnt_in   = byte_val;
                  BIDX_W'(1): off_in   = {byte_val, off_ff[7:0]};
                  BIDX_W'(2): off_in   = {off_ff[15:8], byte_val};
                  BIDX_W'(3): rtype_in = byte_val;
                  default: begin
                     wr_en = (9'(didx) < 9'(cnt_ff)) &&
                             (9'(didx) < 9'(MAX_DATA_BYTES));
                  end
               endcase
               sum_in  = sum_ff + byte_val;
               bidx_in = bidx_ff + BIDX_W'(1);
            end
         end
      end

      if (cmd.word_clear) begin
         widx_in = '0;
      end
      if (cmd.emit_word) begin
         widx_in = widx_ff + WIDX_W'(1);
      end
      if (cmd.emit_line) begin
         if (line_status == LS_END) begin
            seen_in = 1'b1;
         end
         if (line_status >= LS_NO_COLON) begin
            failed_in = 1'b1;
         end
      end
      if (cmd.clear_line) begin
         pos_in   = '0;
         nib_in   = '0;
         bidx_in  = '0;
         cnt_in   = '0;
         off_in   = '0;
         rtype_in = '0;
         sum_in   = '0;
         fault_in = FAULT_NONE;
         endm_in  = 1'b1;
      end
      if (cmd.clear_file) begin
         failed_in = 1'b0;
         seen_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         nib_ff    <= '0;
         bidx_ff   <= '0;
         cnt_ff    <= '0;
         off_ff    <= '0;
         rtype_ff  <= '0;
         sum_ff    <= '0;
         fault_ff  <= FAULT_NONE;
         endm_ff   <= 1'b1;
         failed_ff <= 1'b0;
         seen_ff   <= 1'b0;
         widx_ff   <= '0;
      end else begin
         pos_ff    <= pos_in;
         nib_ff    <= nib_in;
         bidx_ff   <= bidx_in;
         cnt_ff    <= cnt_in;
         off_ff    <= off_in;
         rtype_ff  <= rtype_in;
         sum_ff    <= sum_in;
         fault_ff  <= fault_in;
         endm_ff   <= endm_in;
         failed_ff <= failed_in;
         seen_ff   <= seen_in;
         widx_ff   <= widx_in;
      end
   end

   // data bytes, even and odd banks so one read gives a whole word
   always_ff @(posedge clock) begin
      if (wr_en && !didx[0]) begin
         even_mem[wr_addr] <= byte_val;
      end
      if (wr_en && didx[0]) begin
         odd_mem[wr_addr] <= byte_val;
      end
      even_rd_ff <= even_mem[widx_ff];
      odd_rd_ff  <= odd_mem[widx_ff];
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.emit_word) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_WORD;
         rsp_addr_in   = off_ff[15:1] + 15'(widx_ff);
         rsp_data_in   = {even_rd_ff, odd_rd_ff};
         rsp_status_in = '0;
         rsp_last_in   = 1'b0;
      end else if (cmd.emit_line) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_LINE;
         rsp_addr_in   = '0;
         rsp_data_in   = '0;
         rsp_status_in = line_status;
         rsp_last_in   = cmd.last;
      end else if (cmd.emit_file) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_FILE;
         rsp_addr_in   = '0;
         rsp_data_in   = '0;
         rsp_status_in = {1'b0, file_status};
         rsp_last_in   = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff   <= rsp_kind_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_word_address = rsp_addr_ff;
   assign rsp_word_data    = rsp_data_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ===== sv/intel_hex_record_checker_unit.sv =====
// A plain character gives no result. A line end gives its first result from the
// result register after the LINE state (status only) or READ and WORD (data).
// Input: one character per cycle while idle; a data line end holds input for a
// buffer read (READ) and result load (WORD) per word write, then the line status
// and, on end of file, the file status. Reset is synchronous, active high.
// ----------------------------------------------------------------------------
// intel_hex_record_checker_unit
// Checks hex file lines character by character and issues word writes and
// line and file status.
// ----------------------------------------------------------------------------
module intel_hex_record_checker_unit #(
   parameter int unsigned MAX_DATA_BYTES = ihrc_pkg::MAX_DATA_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [14:0] rsp_word_address,
   output logic [15:0] rsp_word_data,
   output logic [2:0]  rsp_status,
   output logic        rsp_last
);
   import ihrc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   ihrc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_char_in (req_char_in),
      .dp_status   (dp_status),
      .cmd         (cmd)
   );

   ihrc_dpath #(
      .MAX_DATA_BYTES (MAX_DATA_BYTES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_char_in      (req_char_in),
      .cmd              (cmd),
      .dp_status        (dp_status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_word_address (rsp_word_address),
      .rsp_word_data    (rsp_word_data),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== sv/ihrc_checker.sv =====
// ----------------------------------------------------------------------------
// ihrc_checker
// Port-level checks on the hex record checker, bound to the top level.
// ----------------------------------------------------------------------------
module ihrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_command,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [2:0]  rsp_status,
   input logic        rsp_last
);
   import ihrc_pkg::*;

   // result held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_status))
      else $error("result item changed while stalled");

   // file status closes the results of an item
   a_file_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FILE |-> rsp_last)
      else $error("file status item without last");

   // a word write is always followed by a line status
   a_word_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_WORD |-> !rsp_last && rsp_status == 3'd0)
      else $error("word write item marked last or with status");

   // end of file always produces results, so input stalls next cycle
   a_eof_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_EOF |=> req_stall)
      else $error("input not stalled after end of file item");

endmodule

bind intel_hex_record_checker_unit ihrc_checker u_ihrc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_command (req_command),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_kind    (rsp_kind),
   .rsp_status  (rsp_status),
   .rsp_last    (rsp_last)
);

// ===== bench/intel_hex_record_checker_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// intel_hex_record_checker_unit_tb
// Feeds hex file text one character at a time: a table of hand-written lines
// with known outcomes, then random files built mostly from well-formed records
// with some broken lines and noise mixed in. Every word write and status item
// is checked against the table or a parser model in step with accepted input.
// ----------------------------------------------------------------------------
module intel_hex_record_checker_unit_tb;
   import ihrc_pkg::*;

   localparam int MAX_BYTES   = MAX_DATA_BYTES_DEF;
   localparam int RUN_LIMIT   = 400000;
   localparam int TOTAL_ITEMS = 400;
   localparam logic [8*11-1:0] END_RECORD_TEXT = ":00000001FF";

   typedef enum logic [1:0] {TERM_CR, TERM_LF, TERM_CRLF, TERM_EOF} term_type;
   typedef enum logic [1:0] {
      STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
   } stall_mode_type;
   typedef enum logic [2:0] {
      FLAW_CHECKSUM, FLAW_COUNT, FLAW_OVERSIZE, FLAW_DROP_DIGIT, FLAW_BAD_CHAR, FLAW_NO_COLON
   } flaw_type;

   typedef struct packed {
      kind_type    kind;
      logic [14:0] addr;
      logic [15:0] data;
      logic [2:0]  status;
      logic        last;
   } hex_result_type;

   typedef struct {
      string           text;
      term_type        term;
      bit              typed;
      bit              has_line;
      line_status_type line_code;
      file_status_type file_code;
   } dir_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = CMD_CHAR;
   logic [7:0]  req_char_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [14:0] rsp_word_address;
   logic [15:0] rsp_word_data;
   logic [2:0]  rsp_status;
   logic        rsp_last;

   hex_result_type awaited_results[$];
   hex_result_type item_results[$];
   dir_row_type    dir_rows[$];
   logic [7:0]     line_q[$];

   int             fail_count = 0;
   int             cycle_count = 0;
   int             burst_left = 0;
   int             items_sent = 0;
   int             words_seen = 0;
   int             lines_seen = 0;
   int             files_seen = 0;
   int             stall_tick = 0;
   stall_mode_type stall_mode = STALL_NONE;

   // parser model state
   logic [9:0]      line_len = '0;
   logic [3:0]      hi_nibble = '0;
   logic [8:0]      bytes_seen = '0;
   logic [7:0]      hdr_count = '0;
   logic [15:0]     hdr_offset = '0;
   logic [7:0]      hdr_type = '0;
   logic [7:0]      byte_sum = '0;
   logic [7:0]      payload [MAX_BYTES];
   line_status_type first_fault = FAULT_NONE;
   logic            end_text_ok = 1'b1;
   logic            file_bad = 1'b0;
   logic            end_found = 1'b0;

   intel_hex_record_checker_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_char_in(req_char_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_word_address(rsp_word_address),
      .rsp_word_data(rsp_word_data),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $error("run stopped at the cycle limit with %0d results outstanding",
             awaited_results.size());
      $display("intel_hex_record_checker_unit verification failed");
      $finish;
   end

   function automatic int digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] base;
      if (v < 10) return 8'("0" + v);
      base = $urandom_range(0, 1) ? "a" : "A";
      return 8'(base + v - 10);
   endfunction

   function automatic void put_hex(input logic [7:0] b);
      line_q.push_back(hex_char(b[7:4]));
      line_q.push_back(hex_char(b[3:0]));
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic clear_hex_line();
      line_len    = '0;
      hi_nibble   = '0;
      bytes_seen  = '0;
      hdr_count   = '0;
      hdr_offset  = '0;
      hdr_type    = '0;
      byte_sum    = '0;
      first_fault = FAULT_NONE;
      end_text_ok = 1'b1;
   endtask

   task automatic take_hex_char(input logic [7:0] ch);
      int         pos;
      int         digit;
      int         slot;
      logic [7:0] b;
      pos = int'(line_len);
      if (line_len != POS_MAX) line_len++;
      if (pos >= int'(END_LEN)) begin
         end_text_ok = 1'b0;
      end else if (ch != END_RECORD_TEXT[8*(int'(END_LEN)-1-pos) +: 8]) begin
         end_text_ok = 1'b0;
      end
      if (first_fault != FAULT_NONE) return;
      if (pos == 0) begin
         if (ch != CHAR_COLON) first_fault = LS_NO_COLON;
         return;
      end
      digit = digit_value(ch);
      if (digit < 0) begin
         first_fault = LS_MALFORMED;
         return;
      end
      if (bytes_seen >= MAX_BYTES + HDR_BYTES) begin
         first_fault = LS_TOO_LONG;
         return;
      end
      if (pos % 2 == 1) begin
         hi_nibble = digit[3:0];
      end else begin
         b = {hi_nibble, digit[3:0]};
         case (bytes_seen)
            0: hdr_count = b;
            1: hdr_offset[15:8] = b;
            2: hdr_offset[7:0] = b;
            3: hdr_type = b;
            default: begin
               slot = int'(bytes_seen) - 4;
               if (slot < hdr_count && slot < MAX_BYTES) payload[slot] = b;
            end
         endcase
         byte_sum = byte_sum + b;
         bytes_seen++;
      end
   endtask

   task automatic close_hex_line();
      line_status_type verdict;
      int              n_words;
      if (line_len == 0) return;
      if (!file_bad) begin
         if (end_text_ok && line_len == END_LEN) begin
            verdict = LS_END;
            end_found = 1'b1;
         end else if (first_fault != FAULT_NONE) begin
            verdict = first_fault;
         end else if (line_len[0] == 1'b0) begin
            verdict = LS_MALFORMED;
         end else if (bytes_seen < HDR_BYTES || bytes_seen != hdr_count + HDR_BYTES) begin
            verdict = LS_LENGTH;
         end else if (byte_sum != 0) begin
            verdict = LS_CHECKSUM;
         end else if (hdr_type != 0) begin
            verdict = LS_OTHER;
         end else begin
            verdict = LS_DATA;
            n_words = hdr_count / 2;
            for (int i = 0; i < n_words && 2 * i + 1 < MAX_BYTES; i++) begin
               item_results.push_back('{kind: KIND_WORD, addr: 15'((hdr_offset >> 1) + i),
                                        data: {payload[2*i], payload[2*i+1]},
                                        status: '0, last: 1'b0});
            end
         end
         item_results.push_back('{kind: KIND_LINE, addr: '0, data: '0,
                                  status: verdict, last: 1'b0});
         if (verdict >= LS_NO_COLON) file_bad = 1'b1;
      end
      clear_hex_line();
   endtask

   // works out every result that one accepted item causes
   task automatic parse_hex_item(input logic cmd, input logic [7:0] ch);
      logic [2:0] fstat;
      if (cmd == CMD_EOF) begin
         close_hex_line();
         fstat = file_bad ? 3'(FS_BAD_LINE) : (end_found ? 3'(FS_VALID) : 3'(FS_NO_END));
         item_results.push_back('{kind: KIND_FILE, addr: '0, data: '0,
                                  status: fstat, last: 1'b0});
         clear_hex_line();
         file_bad  = 1'b0;
         end_found = 1'b0;
      end else if (ch == CHAR_CR || ch == CHAR_LF) begin
         close_hex_line();
      end else begin
         take_hex_char(ch);
      end
      if (item_results.size() != 0) item_results[$].last = 1'b1;
   endtask

   task automatic send_item(input logic cmd, input logic [7:0] ch, input bit predicted);
      int gap;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_char_in <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      items_sent++;
      parse_hex_item(cmd, ch);
      if (predicted) begin
         foreach (item_results[i]) awaited_results.push_back(item_results[i]);
      end
      item_results.delete();
   endtask

   task automatic send_line_end(input term_type term, input bit predicted);
      case (term)
         TERM_CR: send_item(CMD_CHAR, CHAR_CR, predicted);
         TERM_LF: send_item(CMD_CHAR, CHAR_LF, predicted);
         TERM_CRLF: begin
            send_item(CMD_CHAR, CHAR_CR, predicted);
            send_item(CMD_CHAR, CHAR_LF, predicted);
         end
         default: send_item(CMD_EOF, 8'($urandom), predicted);
      endcase
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic make_record(input logic [7:0] count, input logic [15:0] offset,
                              input logic [7:0] rtype, input int ndata);
      logic [7:0] sum;
      logic [7:0] b;
      line_q.delete();
      line_q.push_back(CHAR_COLON);
      sum = count + offset[15:8] + offset[7:0] + rtype;
      put_hex(count);
      put_hex(offset[15:8]);
      put_hex(offset[7:0]);
      put_hex(rtype);
      for (int i = 0; i < ndata; i++) begin
         b = 8'($urandom);
         if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
         put_hex(b);
         sum = sum + b;
      end
      put_hex(~sum + 8'd1);
   endtask

   task automatic add_row(input string text, input term_type term, input bit typed,
                          input bit has_line, input line_status_type lcode,
                          input file_status_type fcode);
      dir_row_type row;
      row.text      = text;
      row.term      = term;
      row.typed     = typed;
      row.has_line  = has_line;
      row.line_code = lcode;
      row.file_code = fcode;
      dir_rows.push_back(row);
   endtask

   // result side: stall pattern and checking
   always @(posedge clock) begin
      hex_result_type want;
      stall_tick <= stall_tick + 1;
      if (stall_tick % 64 == 0) stall_mode <= stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (stall_tick % 7 < 4);
      endcase
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $error("item with nothing awaited: kind %0d address %0d data %0h status %0d",
                   rsp_kind, rsp_word_address, rsp_word_data, rsp_status);
            fail_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("word_address", want.addr, rsp_word_address);
            check_field("word_data", want.data, rsp_word_data);
            check_field("status", want.status, rsp_status);
            check_field("last", want.last, rsp_last);
            case (want.kind)
               KIND_WORD: words_seen++;
               KIND_LINE: lines_seen++;
               default:   files_seen++;
            endcase
         end
      end
   end

   initial begin
      int       roll;
      int       dlen;
      int       nlen;
      int       idx;
      int       drain;
      bit       drained_once;
      term_type term;
      flaw_type flaw;
      logic [7:0] c;

      drained_once = 1'b0;
      foreach (payload[i]) payload[i] = '0;

      add_row("", TERM_EOF, 1, 0, LS_DATA, FS_NO_END);
      add_row(":00000001FF", TERM_CR, 1, 1, LS_END, FS_VALID);
      add_row("", TERM_LF, 1, 0, LS_DATA, FS_VALID);
      add_row("", TERM_EOF, 1, 0, LS_DATA, FS_VALID);
      add_row(":0400100001020304E2", TERM_LF, 0, 0, LS_DATA, FS_VALID);
      add_row(":10FFFE00FFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFF03", TERM_CRLF, 0, 0, LS_DATA,
              FS_VALID);
      add_row(":0300000012345661", TERM_CR, 0, 0, LS_DATA, FS_VALID);
      add_row(":0000000000", TERM_LF, 1, 1, LS_DATA, FS_VALID);
      add_row(":00000001ff", TERM_LF, 1, 1, LS_OTHER, FS_VALID);
      add_row(":020000021200EA", TERM_CR, 1, 1, LS_OTHER, FS_VALID);
      add_row(":00000001FF", TERM_EOF, 1, 1, LS_END, FS_VALID);
      add_row(":0100000000", TERM_LF, 1, 1, LS_LENGTH, FS_VALID);
      add_row(":0400100001020304E2", TERM_LF, 1, 0, LS_DATA, FS_VALID);
      add_row("", TERM_EOF, 1, 0, LS_DATA, FS_BAD_LINE);
      add_row("X00000001FF", TERM_EOF, 1, 1, LS_NO_COLON, FS_BAD_LINE);
      add_row(":0G", TERM_EOF, 1, 1, LS_MALFORMED, FS_BAD_LINE);
      add_row(":000", TERM_EOF, 1, 1, LS_MALFORMED, FS_BAD_LINE);
      add_row(":0000", TERM_EOF, 1, 1, LS_LENGTH, FS_BAD_LINE);
      add_row(":0000000001", TERM_EOF, 1, 1, LS_CHECKSUM, FS_BAD_LINE);
      add_row(":000000000000000000000000000000000000000000000000", TERM_EOF, 1, 1,
              LS_TOO_LONG, FS_BAD_LINE);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         for (int i = 0; i < dir_rows[r].text.len(); i++) begin
            send_item(CMD_CHAR, dir_rows[r].text[i], !dir_rows[r].typed);
         end
         send_line_end(dir_rows[r].term, !dir_rows[r].typed);
         if (dir_rows[r].typed) begin
            if (dir_rows[r].has_line) begin
               awaited_results.push_back('{kind: KIND_LINE, addr: '0, data: '0,
                                           status: dir_rows[r].line_code, last: 1'b0});
            end
            if (dir_rows[r].term == TERM_EOF) begin
               awaited_results.push_back('{kind: KIND_FILE, addr: '0, data: '0,
                                           status: 3'(dir_rows[r].file_code), last: 1'b0});
            end
            if (dir_rows[r].has_line || dir_rows[r].term == TERM_EOF) begin
               awaited_results[$].last = 1'b1;
            end
         end
      end
      hold_until_drained();

      while (items_sent < TOTAL_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (file_bad && $urandom_range(0, 1) == 1) roll = 99;
         dlen = ($urandom_range(0, 3) == 0) ? MAX_BYTES : $urandom_range(0, 8);
         term = TERM_CR;
         line_q.delete();
         if (roll < 50) begin
            make_record(8'(dlen), 16'($urandom), 8'h00, dlen);
         end else if (roll < 58) begin
            dlen = $urandom_range(0, 4);
            make_record(8'(dlen), 16'($urandom), 8'($urandom_range(1, 255)), dlen);
         end else if (roll < 62) begin
            for (int k = 0; k < int'(END_LEN); k++) begin
               line_q.push_back(END_RECORD_TEXT[8*(int'(END_LEN)-1-k) +: 8]);
            end
         end else if (roll < 80) begin
            make_record(8'(dlen), 16'($urandom), $urandom_range(0, 1) ? 8'h00 : 8'h01, dlen);
            flaw = flaw_type'($urandom_range(0, 5));
            case (flaw)
               FLAW_CHECKSUM: line_q[line_q.size()-1] = (line_q[$] == "0") ? "1" : "0";
               FLAW_COUNT: begin
                  make_record(8'($urandom_range(0, 20)), 16'($urandom), 8'h00,
                              $urandom_range(0, 20));
               end
               FLAW_OVERSIZE: begin
                  dlen = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 8);
                  make_record(8'(dlen), 16'($urandom), 8'h00, dlen);
               end
               FLAW_DROP_DIGIT: line_q.delete($urandom_range(1, line_q.size() - 1));
               FLAW_BAD_CHAR: begin
                  c = 8'($urandom);
                  if (c == CHAR_CR || c == CHAR_LF) c = "g";
                  line_q[$urandom_range(1, line_q.size() - 1)] = c;
               end
               default: begin
                  c = 8'($urandom);
                  if (c == CHAR_CR || c == CHAR_LF || c == CHAR_COLON) c = "#";
                  line_q[0] = c;
               end
            endcase
         end else if (roll < 88) begin
            // blank line
         end else if (roll < 94) begin
            nlen = $urandom_range(1, 40);
            repeat (nlen) begin
               line_q.push_back($urandom_range(0, 1) ? 8'($urandom) : hex_char(4'($urandom)));
            end
            if ($urandom_range(0, 1)) line_q[0] = CHAR_COLON;
         end else begin
            term = TERM_EOF;
         end

         if (roll < 94) begin
            idx = $urandom_range(0, 19);
            if (idx == 0) term = TERM_EOF;
            else if (idx < 9) term = TERM_CR;
            else if (idx < 16) term = TERM_LF;
            else term = TERM_CRLF;
         end

         foreach (line_q[i]) send_item(CMD_CHAR, line_q[i], 1'b1);
         send_line_end(term, 1'b1);

         if (term == TERM_EOF && (!drained_once || $urandom_range(0, 7) == 0)) begin
            drained_once = 1'b1;
            hold_until_drained();
         end
      end
      send_item(CMD_EOF, 8'($urandom), 1'b1);
      req_valid <= 1'b0;

      drain = 0;
      while (awaited_results.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      if (awaited_results.size() != 0) begin
         $error("%0d expected results never arrived", awaited_results.size());
         fail_count++;
      end
      repeat (20) @(posedge clock);

      $display("%0d characters and end-of-file commands sent (%0d directed lines)",
               items_sent, dir_rows.size());
      $display("checked %0d word writes, %0d line status and %0d file status items",
               words_seen, lines_seen, files_seen);
      if (fail_count == 0) begin
         $display("intel_hex_record_checker_unit verification clean");
      end else begin
         $display("intel_hex_record_checker_unit verification failed");
      end
      $finish;
   end

endmodule
